// ===== rtl/box_blur_3x3_rgb_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for box_blur_3x3_rgb
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_RGB_ASSERT_SVH
`define BOX_BLUR_3X3_RGB_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BB3_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bb3 check failed");

// next-cycle implication
`define BB3_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bb3 check failed");

`endif

// ===== rtl/bb3_pkg.sv =====
// ---------------------------------------------------------------------------
// bb3_pkg
// Shared constants, types and helpers of the 3x3 RGB box blur.
// ---------------------------------------------------------------------------
package bb3_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 16;
    localparam int WID_W     = 11;
    localparam int PIX_W     = 24;
    localparam int SUM_W     = 12;
    localparam int X_W       = 13;
    localparam int RCP_W     = 20;
    localparam int PROD_W    = X_W + RCP_W;
    localparam int OUT_W     = 56;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SUM,
        ST_MUL,
        ST_FIX
    } state_t;

    typedef struct packed {
        logic       accept;
        logic       load;
        logic       sum_en;
        logic       mul_en;
        logic       out_wr;
        logic       advance;
        logic [1:0] sel;      // {dr, dc}
    } cmd_t;

    typedef struct packed {
        logic [3:0] mask;     // which of the four results this pixel yields
        logic       out_busy;
    } stat_t;

    // ceil(2^20 / (2n)) for the pixel counts that occur
    function automatic logic [RCP_W-1:0] recip(input logic [3:0] n);
        logic [RCP_W-1:0] m;
        case (n)
            4'd1:    m = 20'd524288;
            4'd2:    m = 20'd262144;
            4'd3:    m = 20'd174763;
            4'd4:    m = 20'd131072;
            4'd6:    m = 20'd87382;
            4'd9:    m = 20'd58255;
            default: m = 20'd524288;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/bb3_ctrl.sv =====
// ---------------------------------------------------------------------------
// bb3_ctrl
// Sequencer: accept, line store update, then one pass per result.
// ---------------------------------------------------------------------------
module bb3_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  bb3_pkg::stat_t  stat,
    output bb3_pkg::cmd_t   cmd
);

    bb3_pkg::state_t state_reg, state_next;
    logic [1:0] k_reg, k_next;

    // first set mask bit at or after start
    function automatic logic [2:0] find_from(input logic [3:0] mask,
                                             input logic [2:0] start);
        logic [2:0] res;
        res = 3'd4;
        for (int i = 3; i >= 0; i--)
        begin
            if (mask[i] && (3'(i) >= start))
                res = 3'(i);
        end
        return res;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bb3_pkg::ST_IDLE;
            k_reg     <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        logic [2:0] nxt;
        state_next = state_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.sel    = k_reg;
        in_ready   = 1'b0;
        nxt        = 3'd4;
        case (state_reg)
            bb3_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = bb3_pkg::ST_LOAD;
                end
            end
            bb3_pkg::ST_LOAD:
            begin
                cmd.load = 1'b1;
                nxt = find_from(stat.mask, 3'd0);
                if (nxt[2])
                begin
                    cmd.advance = 1'b1;
                    state_next  = bb3_pkg::ST_IDLE;
                end
                else
                begin
                    k_next     = nxt[1:0];
                    state_next = bb3_pkg::ST_SUM;
                end
            end
            bb3_pkg::ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = bb3_pkg::ST_MUL;
            end
            bb3_pkg::ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = bb3_pkg::ST_FIX;
            end
            bb3_pkg::ST_FIX:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_wr = 1'b1;
                    nxt = find_from(stat.mask, {1'b0, k_reg} + 3'd1);
                    if (nxt[2])
                    begin
                        cmd.advance = 1'b1;
                        state_next  = bb3_pkg::ST_IDLE;
                    end
                    else
                    begin
                        k_next     = nxt[1:0];
                        state_next = bb3_pkg::ST_SUM;
                    end
                end
            end
            default:
            begin
                state_next = bb3_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/bb3_datapath.sv =====
// ---------------------------------------------------------------------------
// bb3_datapath
// Line stores, 3x3 window, counters, masked sum, reciprocal divide, output.
// ---------------------------------------------------------------------------
module bb3_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bb3_pkg::cmd_t              cmd,
    output bb3_pkg::stat_t             stat,
    input  logic [bb3_pkg::PIX_W-1:0]  in_pixel,
    input  logic                       cfg_valid,
    input  logic                       cfg_index,
    input  logic [15:0]                cfg_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [bb3_pkg::OUT_W-1:0]  out_data,
    output logic                       out_last
);

    logic [bb3_pkg::PIX_W-1:0] older_mem  [bb3_pkg::MAX_WIDTH];
    logic [bb3_pkg::PIX_W-1:0] recent_mem [bb3_pkg::MAX_WIDTH];

    logic [bb3_pkg::WID_W-1:0] width_reg;
    logic [bb3_pkg::ROW_W-1:0] height_reg;
    logic [bb3_pkg::ROW_W-1:0] row_reg;
    logic [bb3_pkg::COL_W-1:0] col_reg;
    logic [bb3_pkg::PIX_W-1:0] px_reg, top_reg, mid_reg;
    logic [bb3_pkg::PIX_W-1:0] win_reg [9];

    logic [bb3_pkg::X_W-1:0]    x_reg    [3];
    logic [bb3_pkg::PROD_W-1:0] prod_reg [3];
    logic [3:0]                 n_reg;
    logic [bb3_pkg::ROW_W-1:0]  orow_reg;
    logic [bb3_pkg::COL_W-1:0]  ocol_reg;
    logic                       odone_reg;

    logic                       out_valid_reg;
    logic [bb3_pkg::OUT_W-1:0]  out_data_reg;
    logic                       out_last_reg;

    logic [bb3_pkg::WID_W-1:0]  w_eff;
    logic [bb3_pkg::ROW_W-1:0]  h_eff;
    logic                       last_col, last_row;

    logic [bb3_pkg::SUM_W-1:0]  sum_c [3];
    logic [3:0]                 n_c;
    logic [bb3_pkg::X_W-1:0]    x_c   [3];
    logic [7:0]                 q_c   [3];

    // effective geometry
    always_comb
    begin
        if (width_reg == '0)
            w_eff = bb3_pkg::WID_W'(1);
        else if (width_reg > bb3_pkg::WID_W'(bb3_pkg::MAX_WIDTH))
            w_eff = bb3_pkg::WID_W'(bb3_pkg::MAX_WIDTH);
        else
            w_eff = width_reg;
        h_eff = (height_reg == '0) ? bb3_pkg::ROW_W'(1) : height_reg;
        last_col = ({1'b0, col_reg} + bb3_pkg::WID_W'(1)) >= w_eff;
        last_row = ({1'b0, row_reg} + 17'd1) >= {1'b0, h_eff};
    end

    assign stat.mask[0]  = (row_reg != '0) && (col_reg != '0);
    assign stat.mask[1]  = (row_reg != '0) && last_col;
    assign stat.mask[2]  = last_row && (col_reg != '0);
    assign stat.mask[3]  = last_row && last_col;
    assign stat.out_busy = out_valid_reg && !out_ready;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bb3_pkg::WID_W'(bb3_pkg::MAX_WIDTH);
            height_reg <= bb3_pkg::ROW_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bb3_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data[bb3_pkg::WID_W-1:0];
                bb3_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default:                   width_reg  <= width_reg;
            endcase
        end
    end

    // line stores: read on accept, write back on load
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            top_reg <= older_mem[col_reg];
            mid_reg <= recent_mem[col_reg];
            px_reg  <= in_pixel;
        end
        if (cmd.load)
        begin
            older_mem[col_reg]  <= mid_reg;
            recent_mem[col_reg] <= px_reg;
        end
    end

    // window and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i*3]   <= win_reg[i*3+1];
                    win_reg[i*3+1] <= win_reg[i*3+2];
                end
                win_reg[2] <= top_reg;
                win_reg[5] <= mid_reg;
                win_reg[8] <= px_reg;
            end
            if (cmd.advance)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + bb3_pkg::ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + bb3_pkg::COL_W'(1);
                end
            end
        end
    end

    // masked sum around centre (1+dr, 1+dc); rows above and cols left of the frame drop out
    always_comb
    begin
        int rlo, clo, cr, cc;
        rlo = (row_reg == '0) ? 2 : ((row_reg == bb3_pkg::ROW_W'(1)) ? 1 : 0);
        clo = (col_reg == '0) ? 2 : ((col_reg == bb3_pkg::COL_W'(1)) ? 1 : 0);
        cr  = 1 + int'(cmd.sel[1]);
        cc  = 1 + int'(cmd.sel[0]);
        n_c = '0;
        for (int ch = 0; ch < 3; ch++)
            sum_c[ch] = '0;
        for (int wr = 0; wr < 3; wr++)
        begin
            for (int wc = 0; wc < 3; wc++)
            begin
                if ((wr >= cr - 1) && (wr <= cr + 1) && (wr >= rlo) &&
                    (wc >= cc - 1) && (wc <= cc + 1) && (wc >= clo))
                begin
                    n_c = n_c + 4'd1;
                    for (int ch = 0; ch < 3; ch++)
                        sum_c[ch] = sum_c[ch] +
                            bb3_pkg::SUM_W'(win_reg[wr*3+wc][ch*8 +: 8]);
                end
            end
        end
        for (int ch = 0; ch < 3; ch++)
            x_c[ch] = {sum_c[ch], 1'b0} + bb3_pkg::X_W'(n_c);
    end

    // quotient = floor(x / 2n): reciprocal estimate, corrected down by one
    always_comb
    begin
        logic [8:0]  q0;
        logic [13:0] chk;
        for (int ch = 0; ch < 3; ch++)
        begin
            q0  = prod_reg[ch][bb3_pkg::RCP_W +: 9];
            chk = 14'(q0) * 14'({n_reg, 1'b0});
            if (chk > 14'(x_reg[ch]))
                q0 = q0 - 9'd1;
            q_c[ch] = q0[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_en)
        begin
            for (int ch = 0; ch < 3; ch++)
                x_reg[ch] <= x_c[ch];
            n_reg     <= n_c;
            orow_reg  <= row_reg + bb3_pkg::ROW_W'(cmd.sel[1]) - bb3_pkg::ROW_W'(1);
            ocol_reg  <= col_reg + bb3_pkg::COL_W'(cmd.sel[0]) - bb3_pkg::COL_W'(1);
            odone_reg <= last_row && last_col && cmd.sel[1] && cmd.sel[0];
        end
        if (cmd.mul_en)
        begin
            for (int ch = 0; ch < 3; ch++)
                prod_reg[ch] <= bb3_pkg::PROD_W'(x_reg[ch]) *
                                bb3_pkg::PROD_W'(bb3_pkg::recip(n_reg));
        end
        if (cmd.out_wr)
        begin
            out_data_reg <= {6'd0, ocol_reg, orow_reg, q_c[2], q_c[1], q_c[0]};
            out_last_reg <= odone_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_wr)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== rtl/box_blur_3x3_rgb.sv =====
// ---------------------------------------------------------------------------
// box_blur_3x3_rgb
// 3x3 mean filter over an RGB pixel stream, one frame in raster order.
// ---------------------------------------------------------------------------
// Use:
//  - Pixels enter on the s_axis beat channel, one pixel per beat, row by row.
//  - Blurred pixels leave on m_axis with their row and column; tlast marks the
//    final pixel of the frame. Output lags input by one row and one column;
//    the last column and last row are flushed by the pixels that close them.
//  - frame_width / frame_height are set over the cfg channel (index 0 and 1)
//    while the block is idle; cfg_ready is always high.
// Sequence:
//  - One input beat passes a store read and a window update, then a sum,
//    reciprocal multiply and correction step for each result it releases;
//    the next pixel waits until all are written. The mean unit is the limit.
//  - A finished result sits in the output register; the next pixel is
//    accepted while it waits. If the receiver stalls, the sequencer holds
//    its next result at the correction step until the register frees.
// Reset: counters, window and output valid clear; width = 1024, height = 1.
//  The line stores are not cleared; rows above the frame never enter a mean.
// ---------------------------------------------------------------------------
module box_blur_3x3_rgb (
    input  logic        clk,
    input  logic        rst_n,
    // input beats: [7:0] red_in, [15:8] green_in, [23:16] blue_in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    // output beats: [7:0] red_out, [15:8] green_out, [23:16] blue_out,
    //               [39:24] out_row, [49:40] out_col, [55:50] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tlast,   // frame_done
    // register writes: index 0 frame_width, 1 frame_height
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    bb3_pkg::cmd_t  cmd;
    bb3_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    bb3_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bb3_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_pixel  (s_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// ===== rtl/bb3_port_checker.sv =====
// ---------------------------------------------------------------------------
// bb3_port_checker
// Port-level checks of the box blur, bound to the top level.
// ---------------------------------------------------------------------------
`include "box_blur_3x3_rgb_assert.svh"

module bb3_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // stalled result holds
    `BB3_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // an accepted pixel leaves the sequencer busy, with ready low, once it is taken
    `BB3_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a new result is loaded only while the sequencer is busy
    `BB3_ASSERT_NOW(a_result_from_busy, $rose(m_axis_tvalid), !$past(s_axis_tready))

endmodule

bind box_blur_3x3_rgb bb3_port_checker u_bb3_port_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
